// ===== sv/qlt_pkg.sv =====
// ----------------------------------------------------------------------------
// qlt_pkg
// shared constants, types and helpers of the q-table update block
// ----------------------------------------------------------------------------
package qlt_pkg;

    localparam int NUM_ACTIONS = 5;
    localparam int NUM_STATES  = 1024;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int LANE_W      = $clog2(NUM_ACTIONS);
    localparam int Q_W         = 16;
    localparam int ACT_W       = 4;
    localparam int RATE_W      = 17;
    localparam int TENTH_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int ONE_FIX     = 65536;
    localparam int GREEDY_FLOOR = -8192;

    localparam logic [1:0] REQ_DECIDE = 2'd0;
    localparam logic [1:0] REQ_GOAL   = 2'd1;
    localparam logic [1:0] REQ_CAUGHT = 2'd2;
    localparam logic [1:0] REQ_IGNORE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_MIN      = 3'd4;

    typedef logic [NUM_ACTIONS-1:0][Q_W-1:0] row_t;

    typedef struct packed {
        logic                  start;
        logic [RATE_W-1:0]     alpha;
        logic [RATE_W-1:0]     gamma;
        logic signed [Q_W-1:0] q_old;
        logic signed [Q_W-1:0] reward;
        logic signed [Q_W-1:0] q_next;
        logic signed [Q_W-1:0] q_max;
        logic signed [Q_W-1:0] q_min;
    } mac_op_t;

    // reduce a 4-bit draw into the action range
    function automatic logic [LANE_W-1:0] wrap_action(input logic [ACT_W-1:0] v);
        logic [ACT_W-1:0] r;
        r = v;
        for (int i = 0; i < 8; i++)
        begin
            if (r >= ACT_W'(NUM_ACTIONS))
            begin
                r = r - ACT_W'(NUM_ACTIONS);
            end
        end
        return r[LANE_W-1:0];
    endfunction

endpackage

// ===== sv/qlt_if.sv =====
// ----------------------------------------------------------------------------
// qlt request and response channels
// valid/ready channels carrying one request word and one response word
// ----------------------------------------------------------------------------
interface qlt_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [9:0]        state_id;
    logic signed [15:0] reward;
    logic [3:0]        rand_explore;
    logic [3:0]        rand_action;

    modport source (output valid, req_type, state_id, reward, rand_explore, rand_action,
                    input ready);
    modport sink   (input valid, req_type, state_id, reward, rand_explore, rand_action,
                    output ready);
endinterface

interface qlt_rsp_if;
    logic              valid;
    logic              ready;
    logic [3:0]        action;
    logic              updated;
    logic signed [15:0] new_q;

    modport source (output valid, action, updated, new_q, input ready);
    modport sink   (input valid, action, updated, new_q, output ready);
endinterface

// ===== sv/qlt_table.sv =====
// ----------------------------------------------------------------------------
// qlt_table
// q-value memory, one row per state, two registered read ports, one lane
// write port, zero-fill sweep after reset
// ----------------------------------------------------------------------------
module qlt_table
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [qlt_pkg::STATE_W-1:0] rd_addr_a,
    input  logic [qlt_pkg::STATE_W-1:0] rd_addr_b,
    input  logic                        we,
    input  logic [qlt_pkg::STATE_W-1:0] wr_addr,
    input  logic [qlt_pkg::LANE_W-1:0]  wr_lane,
    input  logic [qlt_pkg::Q_W-1:0]     wr_data,
    output qlt_pkg::row_t               rd_row_a,
    output qlt_pkg::row_t               rd_row_b,
    output logic                        clearing
);
    import qlt_pkg::*;

    row_t             mem [NUM_STATES];
    logic [STATE_W:0] clr_cnt_reg;
    logic [STATE_W:0] clr_cnt_next;

    assign clearing     = (clr_cnt_reg < (STATE_W+1)'(NUM_STATES));
    assign clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_cnt_reg[STATE_W-1:0]] <= '0;
        end
        else if (we)
        begin
            mem[wr_addr][wr_lane] <= wr_data;
        end
        if (rd_en)
        begin
            rd_row_a <= mem[rd_addr_a];
            rd_row_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== sv/qlt_mac.sv =====
// ----------------------------------------------------------------------------
// qlt_mac
// blend of old value and target over one shared 18x18 multiplier,
// five steps, then half-up rounding and clamping
// ----------------------------------------------------------------------------
module qlt_mac
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  qlt_pkg::mac_op_t             op,
    output logic                         done,
    output logic signed [qlt_pkg::Q_W-1:0] result
);
    import qlt_pkg::*;

    localparam int ACC_W = 52;
    localparam int P2_W  = 34;

    mac_op_t                  op_reg;
    logic [2:0]               step_reg, step_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [P2_W-1:0]   p2_reg, p2_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [17:0]       mx, my;
    logic signed [35:0]       prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [19:0]       rnd;

    always_comb
    begin
        unique case (step_reg)
            3'd0:    mx = signed'({1'b0, op_reg.gamma});
            3'd1:    mx = 18'(ONE_FIX) - signed'({1'b0, op_reg.alpha});
            default: mx = signed'({1'b0, op_reg.alpha});
        endcase
        unique case (step_reg)
            3'd0:    my = 18'(op_reg.q_next);
            3'd1:    my = 18'(op_reg.q_old);
            3'd2:    my = 18'(op_reg.reward);
            3'd3:    my = p2_reg[P2_W-1:16];
            default: my = signed'({2'b00, p2_reg[15:0]});
        endcase
    end

    assign prod     = mx * my;
    assign prod_ext = ACC_W'(prod);

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        p2_next   = p2_reg;
        acc_next  = acc_reg;
        if (op.start)
        begin
            step_next = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            case (step_reg)
                3'd0:    p2_next  = P2_W'(prod);
                3'd1:    acc_next = prod_ext <<< 16;
                3'd2:    acc_next = acc_reg + (prod_ext <<< 16);
                3'd3:    acc_next = acc_reg + (prod_ext <<< 16);
                default:
                begin
                    acc_next  = acc_reg + prod_ext;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.start)
        begin
            op_reg <= op;
        end
        p2_reg  <= p2_next;
        acc_reg <= acc_next;
    end

    // floor((sum + 2^31) / 2^32)
    assign rnd_sum = acc_reg + (ACC_W'(1) <<< 31);
    assign rnd     = rnd_sum[ACC_W-1:32];

    always_comb
    begin
        if (rnd > 20'(op_reg.q_max))
        begin
            result = op_reg.q_max;
        end
        else if (rnd < 20'(op_reg.q_min))
        begin
            result = op_reg.q_min;
        end
        else
        begin
            result = rnd[Q_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== sv/q_learning_table_update.sv =====
// ----------------------------------------------------------------------------
// q_learning_table_update
// tabular q-learning with epsilon-greedy choice over a q4.12 table
// ----------------------------------------------------------------------------
// One request word at a time: the new row and the previous row are read at the
// accepting edge, then come action selection, five steps of the shared
// multiplier, the hand-over of the product and the write-back, with which the
// response word is loaded. The next request is taken after the return to idle;
// a response word still waiting holds the write-back. After reset the table is
// zero-filled one row per cycle, during which no request is taken.
// Configuration writes are taken at any time but belong in idle periods.
module q_learning_table_update
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [qlt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qlt_pkg::RATE_W-1:0]      cfg_data,
    qlt_req_if.sink                         req,
    qlt_rsp_if.source                       rsp
);
    import qlt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PICK = 2'd1;
    localparam logic [1:0] S_MAC  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [RATE_W-1:0]     learn_rate_reg, discount_reg;
    logic [TENTH_W-1:0]    explore_reg;
    logic signed [Q_W-1:0] q_max_reg, q_min_reg;

    logic [STATE_W-1:0]    prev_state_reg;
    logic [LANE_W-1:0]     prev_action_reg;
    logic                  prev_valid_reg;

    logic [1:0]            type_reg;
    logic [STATE_W-1:0]    sid_reg;
    logic signed [Q_W-1:0] reward_reg;
    logic [TENTH_W-1:0]    rex_reg;
    logic [ACT_W-1:0]      rac_reg;
    logic [LANE_W-1:0]     act_reg, act_next;

    logic                  rsp_valid_reg;
    logic [ACT_W-1:0]      rsp_action_reg;
    logic                  rsp_updated_reg;
    logic signed [Q_W-1:0] rsp_new_q_reg;

    row_t                  row_a, row_b;
    logic                  clearing;
    logic                  accept;
    logic                  finish;
    logic                  upd;
    logic                  mac_done;
    logic signed [Q_W-1:0] mac_result;
    mac_op_t               mac_op;

    logic signed [Q_W-1:0]     row_max;
    logic [NUM_ACTIONS-1:0]    marks;
    logic [LANE_W-1:0]         first_max;
    logic [LANE_W-1:0]         best;
    logic [RATE_W-1:0]         alpha, gamma;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !clearing;
    assign upd       = prev_valid_reg && (type_reg != REQ_IGNORE);
    assign finish    = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    qlt_table u_table
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (req.state_id[STATE_W-1:0]),
        .rd_addr_b (prev_state_reg),
        .we        (finish && upd),
        .wr_addr   (prev_state_reg),
        .wr_lane   (prev_action_reg),
        .wr_data   (mac_result),
        .rd_row_a  (row_a),
        .rd_row_b  (row_b),
        .clearing  (clearing)
    );

    // row maximum and the columns holding it
    always_comb
    begin
        row_max = signed'(row_a[0]);
        for (int i = 1; i < NUM_ACTIONS; i++)
        begin
            if (signed'(row_a[i]) > row_max)
            begin
                row_max = signed'(row_a[i]);
            end
        end
        marks     = '0;
        first_max = '0;
        for (int i = NUM_ACTIONS - 1; i >= 0; i--)
        begin
            if (signed'(row_a[i]) == row_max)
            begin
                marks[i]  = 1'b1;
                first_max = LANE_W'(i);
            end
        end
        if (row_max < Q_W'(GREEDY_FLOOR))
        begin
            best = prev_action_reg;
        end
        else if (marks[prev_action_reg])
        begin
            best = prev_action_reg;
        end
        else
        begin
            best = first_max;
        end
        if (row_max < q_min_reg)
        begin
            act_next = '0;
        end
        else if (rex_reg < explore_reg)
        begin
            act_next = wrap_action(rac_reg);
        end
        else
        begin
            act_next = first_max;
        end
    end

    assign alpha = (learn_rate_reg > RATE_W'(ONE_FIX)) ? RATE_W'(ONE_FIX) : learn_rate_reg;
    assign gamma = (discount_reg > RATE_W'(ONE_FIX)) ? RATE_W'(ONE_FIX) : discount_reg;

    always_comb
    begin
        mac_op.start  = (state_reg == S_PICK);
        mac_op.alpha  = alpha;
        mac_op.gamma  = gamma;
        mac_op.q_old  = signed'(row_b[prev_action_reg]);
        mac_op.reward = reward_reg;
        mac_op.q_max  = q_max_reg;
        mac_op.q_min  = q_min_reg;
        case (type_reg)
            REQ_GOAL:   mac_op.q_next = q_max_reg;
            REQ_CAUGHT: mac_op.q_next = q_min_reg;
            default:    mac_op.q_next = signed'(row_a[best]);
        endcase
    end

    qlt_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (mac_op),
        .done   (mac_done),
        .result (mac_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept)   state_next = S_PICK;
            S_PICK:               state_next = S_MAC;
            S_MAC:  if (mac_done) state_next = S_DONE;
            S_DONE: if (finish)   state_next = S_IDLE;
            default:              state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            learn_rate_reg  <= RATE_W'(6554);
            discount_reg    <= RATE_W'(58982);
            explore_reg     <= TENTH_W'(1);
            q_max_reg       <= 16'sd4096;
            q_min_reg       <= -16'sd4096;
            prev_state_reg  <= '0;
            prev_action_reg <= '0;
            prev_valid_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEARN_RATE: learn_rate_reg <= cfg_data;
                    CFG_DISCOUNT:   discount_reg   <= cfg_data;
                    CFG_EXPLORE:    explore_reg    <= cfg_data[TENTH_W-1:0];
                    CFG_Q_MAX:      q_max_reg      <= signed'(cfg_data[Q_W-1:0]);
                    CFG_Q_MIN:      q_min_reg      <= signed'(cfg_data[Q_W-1:0]);
                    default:        ;
                endcase
            end
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                case (type_reg)
                    REQ_DECIDE:
                    begin
                        prev_state_reg  <= sid_reg;
                        prev_action_reg <= act_reg;
                        prev_valid_reg  <= 1'b1;
                    end
                    REQ_GOAL, REQ_CAUGHT:
                    begin
                        prev_state_reg  <= '0;
                        prev_action_reg <= '0;
                        prev_valid_reg  <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= req.req_type;
            sid_reg    <= req.state_id[STATE_W-1:0];
            reward_reg <= req.reward;
            rex_reg    <= req.rand_explore;
            rac_reg    <= req.rand_action;
        end
        if (state_reg == S_PICK)
        begin
            act_reg <= act_next;
        end
        if (finish)
        begin
            rsp_action_reg  <= (type_reg == REQ_DECIDE) ? ACT_W'(act_reg) : '0;
            rsp_updated_reg <= upd;
            rsp_new_q_reg   <= upd ? mac_result : '0;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.action  = rsp_action_reg;
    assign rsp.updated = rsp_updated_reg;
    assign rsp.new_q   = rsp_new_q_reg;

endmodule

// ===== sv/qlt_checker.sv =====
// ----------------------------------------------------------------------------
// qlt_checker
// port-level checks of the q-table update block
// ----------------------------------------------------------------------------
module qlt_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [3:0]        rsp_action,
    input logic              rsp_updated,
    input logic signed [15:0] rsp_new_q
);
    import qlt_pkg::*;

    // one word in flight
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_zero_q: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_updated |-> rsp_new_q == 16'sd0)
        else $error("new_q set without update");

    a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_action < 4'(NUM_ACTIONS))
        else $error("action out of range");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_q))
        else $error("response word dropped");

endmodule

bind q_learning_table_update qlt_checker u_qlt_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_action  (rsp.action),
    .rsp_updated (rsp.updated),
    .rsp_new_q   (rsp.new_q)
);
